### hdl/qalu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qalu_pkg: shared types and constants for the quaternion unit
// Fixed-point format, operation codes and the item structs of both channels.
// ----------------------------------------------------------------------------
package qalu_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  typedef enum logic [1:0] {
    MODE_PROD = 2'd0,
    MODE_ROT  = 2'd1,
    MODE_IROT = 2'd2,
    MODE_MAT  = 2'd3
  } mode_t;

  typedef logic signed [DATA_WIDTH-1:0] comp_t;

  typedef struct packed {
    mode_t mode;
    logic  conj_a;
    logic  conj_b;
    comp_t a_w;
    comp_t a_x;
    comp_t a_y;
    comp_t a_z;
    comp_t b_w;
    comp_t b_x;
    comp_t b_y;
    comp_t b_z;
  } in_t;

  typedef struct packed {
    logic [1:0] row;
    comp_t      r_w;
    comp_t      r_x;
    comp_t      r_y;
    comp_t      r_z;
    logic       last;
  } out_t;

endpackage
`default_nettype wire

### hdl/quaternion_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_alu: pipelined fixed-point quaternion unit
// Hamilton product (optional conjugates), forward and inverse vector rotation,
// and rotation matrix rows. Every product is rounded to FRAC_BITS, ties away
// from zero; results saturate to DATA_WIDTH.
// ----------------------------------------------------------------------------
// channel   ports                      handshake
// input     start, busy, in_data       item taken when start && !busy
// result    out_strobe, out_data       one strobe per result, no backpressure
//
// An item passes the stage registers, then the output register. Products,
// rotations take one item per cycle while busy is low. A matrix item puts out
// three rows on consecutive cycles, so busy is high while gap_r counts down; that
// gap travels down the pipe and frees the output sequencer for rows 1 and 2.
// Reset (rst_n low, synchronous) clears the valid bits and the row sequencer.
// The receiver cannot stall; the pipe never stops.
// ----------------------------------------------------------------------------
module quaternion_alu
  import qalu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_strobe,
  output out_t      out_data
);

  localparam int DW  = DATA_WIDTH;
  localparam int FB  = FRAC_BITS;
  // rounded product of two components
  localparam int PW1 = 2*DW + 1 - FB;
  // first-level sums: d, t, cross terms, product results
  localparam int SW  = PW1 + 2;
  // matrix entries before saturation
  localparam int MW  = PW1 + 3;
  // rounded second-level product and its cross differences
  localparam int PW2 = DW + SW + 1 - FB;
  localparam int CW  = PW2 + 1;
  localparam int FW  = CW + 2;

  localparam logic signed [63:0] WIDE_LIM = 64'sh1000_0000_0000_0000;
  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
  localparam logic [2*DW:0] HALF1 = (2*DW+1)'(1) << (FB-1);
  localparam logic [DW+SW:0] HALF2 = (DW+SW+1)'(1) << (FB-1);
  localparam logic signed [MW-1:0] ONE = MW'(1) << FB;

  // ---------------- arithmetic helpers ----------------
  function automatic logic signed [PW1-1:0] mul1(input comp_t a, input comp_t b);
    logic signed [2*DW:0] p;
    p = (2*DW+1)'(a) * (2*DW+1)'(b);
    p = p + $signed(HALF1) - $signed((2*DW+1)'(p[2*DW]));
    return $signed(p[2*DW:FB]);
  endfunction

  function automatic logic signed [PW2-1:0] mul2(input comp_t a,
                                                  input logic signed [SW-1:0] b);
    logic signed [DW+SW:0] p;
    p = (DW+SW+1)'(a) * (DW+SW+1)'(b);
    p = p + $signed(HALF2) - $signed((DW+SW+1)'(p[DW+SW]));
    return $signed(p[DW+SW:FB]);
  endfunction

  function automatic logic signed [SW-1:0] clamp_s(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] r;
    r = x;
    if (x > WIDE_LIM) r = SW'(WIDE_LIM);
    if (x < -WIDE_LIM) r = SW'(-WIDE_LIM);
    return r;
  endfunction

  function automatic logic signed [CW-1:0] clamp_c(input logic signed [CW-1:0] x);
    logic signed [CW-1:0] r;
    r = x;
    if (x > WIDE_LIM) r = CW'(WIDE_LIM);
    if (x < -WIDE_LIM) r = CW'(-WIDE_LIM);
    return r;
  endfunction

  function automatic comp_t sat_o(input logic signed [FW-1:0] x);
    comp_t r;
    r = x[DW-1:0];
    if (x > MAXV) r = MAXV;
    if (x < MINV) r = MINV;
    return r;
  endfunction

  function automatic logic signed [SW-1:0] neg_if(input logic n,
                                                   input logic signed [SW-1:0] x);
    return n ? -x : x;
  endfunction

  // ---------------- input control ----------------
  logic       accept;
  logic [1:0] gap_r, gap_nxt;

  assign accept = start && !busy;
  assign busy   = (gap_r != 2'd0);

  always_comb begin
    gap_nxt = gap_r;
    if (gap_r != 2'd0) gap_nxt = gap_r - 2'd1;
    if (accept && in_data.mode == MODE_MAT) gap_nxt = 2'd2;
  end

  // ---------------- stage 1: first-level products ----------------
  // In matrix mode the second operand is v itself, so the same multipliers
  // give the squares, the v_i*v_j terms and w*v_i.
  comp_t u_op [3];
  logic  v1_r, v1_nxt;
  mode_t m1_r;
  logic  ca1_r, cb1_r;
  comp_t s1_r;
  comp_t v1c_r [3];
  logic signed [PW1-1:0] p_sb_r;
  logic signed [PW1-1:0] p_vu_r [3];
  logic signed [PW1-1:0] p_su_r [3];
  logic signed [PW1-1:0] p_vb_r [3];
  logic signed [PW1-1:0] p_x_r  [6];

  always_comb begin
    if (in_data.mode == MODE_MAT) begin
      u_op[0] = in_data.a_x; u_op[1] = in_data.a_y; u_op[2] = in_data.a_z;
    end else begin
      u_op[0] = in_data.b_x; u_op[1] = in_data.b_y; u_op[2] = in_data.b_z;
    end
  end

  assign v1_nxt = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      gap_r <= 2'd0;
    end else begin
      v1_r  <= v1_nxt;
      gap_r <= gap_nxt;
    end
    m1_r     <= in_data.mode;
    ca1_r    <= in_data.conj_a;
    cb1_r    <= in_data.conj_b;
    s1_r     <= in_data.a_w;
    v1c_r[0] <= in_data.a_x;
    v1c_r[1] <= in_data.a_y;
    v1c_r[2] <= in_data.a_z;
    p_sb_r   <= mul1(in_data.a_w, in_data.b_w);
    p_vu_r[0] <= mul1(in_data.a_x, u_op[0]);
    p_vu_r[1] <= mul1(in_data.a_y, u_op[1]);
    p_vu_r[2] <= mul1(in_data.a_z, u_op[2]);
    p_su_r[0] <= mul1(in_data.a_w, u_op[0]);
    p_su_r[1] <= mul1(in_data.a_w, u_op[1]);
    p_su_r[2] <= mul1(in_data.a_w, u_op[2]);
    p_vb_r[0] <= mul1(in_data.a_x, in_data.b_w);
    p_vb_r[1] <= mul1(in_data.a_y, in_data.b_w);
    p_vb_r[2] <= mul1(in_data.a_z, in_data.b_w);
    p_x_r[0] <= mul1(in_data.a_y, u_op[2]);
    p_x_r[1] <= mul1(in_data.a_z, u_op[1]);
    p_x_r[2] <= mul1(in_data.a_z, u_op[0]);
    p_x_r[3] <= mul1(in_data.a_x, u_op[2]);
    p_x_r[4] <= mul1(in_data.a_x, u_op[1]);
    p_x_r[5] <= mul1(in_data.a_y, u_op[0]);
  end

  // ---------------- stage 2: first-level sums ----------------
  logic                 v2_r;
  mode_t                m2_r;
  comp_t                s2_r;
  comp_t                v2c_r [3];
  logic signed [SW-1:0] d2_r;
  logic signed [SW-1:0] t2_r [3];
  comp_t                prod2_r [4];
  comp_t                mat2_r  [9];

  logic signed [SW-1:0] c_raw [3];
  logic signed [SW-1:0] c_pr  [3];
  logic signed [SW-1:0] c_rt  [3];
  logic signed [SW-1:0] d_nxt;
  logic signed [SW-1:0] t_nxt [3];
  logic signed [SW-1:0] w_sum;
  logic signed [SW-1:0] x_sum [3];
  logic signed [MW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [MW-1:0] mat_nxt [9];
  logic                 sg_vu;

  always_comb begin
    sg_vu = ca1_r ^ cb1_r;
    for (int i = 0; i < 3; i++) begin
      c_raw[i] = clamp_s(SW'(p_x_r[2*i]) - SW'(p_x_r[2*i+1]));
      // product: conjugates flip the cross term once each
      c_pr[i]  = neg_if(sg_vu, c_raw[i]);
      // inverse rotation uses u x v
      c_rt[i]  = neg_if(m1_r == MODE_IROT, c_raw[i]);
      t_nxt[i] = clamp_s(SW'(p_su_r[i]) + c_rt[i]);
      x_sum[i] = neg_if(cb1_r, SW'(p_su_r[i])) + neg_if(ca1_r, SW'(p_vb_r[i]))
               + c_pr[i];
    end
    d_nxt = clamp_s(SW'(p_vu_r[0]) + SW'(p_vu_r[1]) + SW'(p_vu_r[2]));
    w_sum = SW'(p_sb_r)
          - neg_if(sg_vu, SW'(p_vu_r[0]) + SW'(p_vu_r[1]) + SW'(p_vu_r[2]));

    xx = MW'(p_vu_r[0]); yy = MW'(p_vu_r[1]); zz = MW'(p_vu_r[2]);
    yz = MW'(p_x_r[0]);  xz = MW'(p_x_r[2]);  xy = MW'(p_x_r[4]);
    wx = MW'(p_su_r[0]); wy = MW'(p_su_r[1]); wz = MW'(p_su_r[2]);
    mat_nxt[0] = MW'(ONE - 2*yy - 2*zz);
    mat_nxt[1] = MW'(2*xy - 2*wz);
    mat_nxt[2] = MW'(2*xz + 2*wy);
    mat_nxt[3] = MW'(2*xy + 2*wz);
    mat_nxt[4] = MW'(ONE - 2*xx - 2*zz);
    mat_nxt[5] = MW'(2*yz - 2*wx);
    mat_nxt[6] = MW'(2*xz - 2*wy);
    mat_nxt[7] = MW'(2*yz + 2*wx);
    mat_nxt[8] = MW'(ONE - 2*xx - 2*yy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    m2_r  <= m1_r;
    s2_r  <= s1_r;
    d2_r  <= d_nxt;
    prod2_r[0] <= sat_o(FW'(w_sum));
    for (int i = 0; i < 3; i++) begin
      v2c_r[i]     <= v1c_r[i];
      t2_r[i]      <= t_nxt[i];
      prod2_r[i+1] <= sat_o(FW'(x_sum[i]));
    end
    for (int k = 0; k < 9; k++) begin
      mat2_r[k] <= sat_o(FW'(mat_nxt[k]));
    end
  end

  // ---------------- stage 3: second-level products ----------------
  logic                 v3_r;
  mode_t                m3_r;
  comp_t                prod3_r [4];
  comp_t                mat3_r  [9];
  logic signed [CW-1:0] q_vd_r [3];
  logic signed [CW-1:0] q_ts_r [3];
  logic signed [CW-1:0] q_x_r  [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    m3_r    <= m2_r;
    prod3_r <= prod2_r;
    mat3_r  <= mat2_r;
    for (int i = 0; i < 3; i++) begin
      q_vd_r[i] <= clamp_c(CW'(mul2(v2c_r[i], d2_r)));
      q_ts_r[i] <= clamp_c(CW'(mul2(s2_r, t2_r[i])));
    end
    q_x_r[0] <= clamp_c(CW'(mul2(v2c_r[1], t2_r[2])));
    q_x_r[1] <= clamp_c(CW'(mul2(v2c_r[2], t2_r[1])));
    q_x_r[2] <= clamp_c(CW'(mul2(v2c_r[2], t2_r[0])));
    q_x_r[3] <= clamp_c(CW'(mul2(v2c_r[0], t2_r[2])));
    q_x_r[4] <= clamp_c(CW'(mul2(v2c_r[0], t2_r[1])));
    q_x_r[5] <= clamp_c(CW'(mul2(v2c_r[1], t2_r[0])));
  end

  // ---------------- stage 4: rotation sums ----------------
  logic                 v4_r;
  mode_t                m4_r;
  comp_t                prod4_r [4];
  comp_t                mat4_r  [9];
  comp_t                rot4_r  [3];
  logic signed [CW-1:0] c2 [3];
  logic signed [FW-1:0] rsum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c2[i] = clamp_c(q_x_r[2*i] - q_x_r[2*i+1]);
      if (m3_r == MODE_IROT) c2[i] = -c2[i];
      rsum[i] = FW'(q_vd_r[i]) + FW'(q_ts_r[i]) + FW'(c2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    m4_r    <= m3_r;
    prod4_r <= prod3_r;
    mat4_r  <= mat3_r;
    for (int i = 0; i < 3; i++) begin
      rot4_r[i] <= sat_o(rsum[i]);
    end
  end

  // ---------------- output register and row sequencer ----------------
  logic       out_strobe_r, out_strobe_nxt;
  out_t       out_r, out_nxt;
  logic [1:0] rows_r, rows_nxt;
  comp_t      hold_r [6];
  comp_t      hold_nxt [6];

  always_comb begin
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    rows_nxt       = rows_r;
    hold_nxt       = hold_r;
    if (rows_r != 2'd0) begin
      // remaining matrix rows, row 1 then row 2
      out_strobe_nxt = 1'b1;
      out_nxt.row    = (rows_r == 2'd2) ? 2'd1 : 2'd2;
      out_nxt.r_w    = '0;
      out_nxt.r_x    = hold_r[0];
      out_nxt.r_y    = hold_r[1];
      out_nxt.r_z    = hold_r[2];
      out_nxt.last   = (rows_r == 2'd1);
      hold_nxt[0] = hold_r[3];
      hold_nxt[1] = hold_r[4];
      hold_nxt[2] = hold_r[5];
      rows_nxt    = rows_r - 2'd1;
    end else if (v4_r) begin
      out_strobe_nxt = 1'b1;
      out_nxt.row    = 2'd0;
      out_nxt.last   = 1'b1;
      case (m4_r)
        MODE_PROD: begin
          out_nxt.r_w = prod4_r[0];
          out_nxt.r_x = prod4_r[1];
          out_nxt.r_y = prod4_r[2];
          out_nxt.r_z = prod4_r[3];
        end
        MODE_MAT: begin
          out_nxt.r_w  = '0;
          out_nxt.r_x  = mat4_r[0];
          out_nxt.r_y  = mat4_r[1];
          out_nxt.r_z  = mat4_r[2];
          out_nxt.last = 1'b0;
          for (int k = 0; k < 6; k++) hold_nxt[k] = mat4_r[k+3];
          rows_nxt = 2'd2;
        end
        default: begin
          out_nxt.r_w = '0;
          out_nxt.r_x = rot4_r[0];
          out_nxt.r_y = rot4_r[1];
          out_nxt.r_z = rot4_r[2];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
      rows_r       <= 2'd0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
      rows_r       <= rows_nxt;
    end
    out_r  <= out_nxt;
    hold_r <= hold_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  // ---------------- assertions ----------------
  a_rows_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.last |=> out_strobe && out_data.row != 2'd0)
    else $error("matrix row missing");

  a_row2_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.row == 2'd2 |-> out_data.last)
    else $error("row 2 not marked last");

  a_mat_gap: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.mode == MODE_MAT |=> busy ##1 busy)
    else $error("matrix item not followed by gap");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    rows_r != 2'd0 |-> !v4_r)
    else $error("pipe item collides with matrix rows");

endmodule
`default_nettype wire
